// ===== design/pfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pfd_pkg - shared types and helpers for the filtered-derivative PID
// Microcode word layout, register indexes, reset values and the rounding and
// clamping helpers used by the datapath.
// ----------------------------------------------------------------------------
package pfd_pkg;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	typedef enum logic [2:0] {
		REG_GAIN_P      = 3'd0,
		REG_GAIN_I      = 3'd1,
		REG_GAIN_D      = 3'd2,
		REG_INT_LIMIT   = 3'd3,
		REG_TICK_PERIOD = 3'd4,
		REG_TICK_RATE   = 3'd5,
		REG_DERIV_ALPHA = 3'd6
	} reg_idx_t;

	localparam logic [15:0] TICK_PERIOD_RST = 16'd328;
	localparam logic [30:0] TICK_RATE_RST   = 31'd13107200;
	localparam logic [16:0] DERIV_ALPHA_RST = 17'd25735;

	// each term is held to +/-2^48 (Q32.32) before the sum
	localparam logic signed [63:0] TERM_LIM     = 64'sd281474976710656;
	localparam logic signed [63:0] TERM_LIM_NEG = -64'sd281474976710656;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_NONE, MUL_GI, MUL_RATE, MUL_TH, MUL_TL, MUL_ALPHA, MUL_P, MUL_GD
	} mul_sel_t;

	// integral lane
	typedef enum logic [2:0] {
		IOP_NONE, IOP_T, IOP_HI, IOP_LO, IOP_INC, IOP_INTEG
	} iop_t;

	// derivative lane
	typedef enum logic [2:0] {
		DOP_NONE, DOP_RAW, DOP_DIF2, DOP_STEP, DOP_FILT
	} dop_t;

	// sum lane
	typedef enum logic [2:0] {
		SOP_NONE, SOP_PSUM, SOP_IACC, SOP_DACC, SOP_OUT
	} sop_t;

	typedef enum logic {
		JMP_NEVER, JMP_NO_ID
	} jmp_t;

	typedef struct packed {
		mul_sel_t msel;
		iop_t     iop;
		dop_t     dop;
		sop_t     sop;
		jmp_t     jmp;
		step_t    target;
		logic     last;
	} ctrl_t;

	// Microprogram. A product issued in one step is consumed in the next.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '{msel: MUL_NONE, iop: IOP_NONE, dop: DOP_NONE, sop: SOP_NONE,
			jmp: JMP_NEVER, target: step_t'(0), last: 1'b0};
		unique case (s)
			step_t'(0): begin
				c.msel   = MUL_GI;
				c.jmp    = JMP_NO_ID;
				c.target = step_t'(5);
			end
			step_t'(1): begin
				c.msel = MUL_RATE;
				c.iop  = IOP_T;
			end
			step_t'(2): begin
				c.msel = MUL_TH;
				c.dop  = DOP_RAW;
			end
			step_t'(3): begin
				c.msel = MUL_TL;
				c.iop  = IOP_HI;
				c.dop  = DOP_DIF2;
			end
			step_t'(4): begin
				c.msel = MUL_ALPHA;
				c.iop  = IOP_LO;
			end
			step_t'(5): begin
				c.msel = MUL_P;
				c.iop  = IOP_INC;
				c.dop  = DOP_STEP;
			end
			step_t'(6): begin
				c.iop = IOP_INTEG;
				c.dop = DOP_FILT;
				c.sop = SOP_PSUM;
			end
			step_t'(7): begin
				c.msel = MUL_GD;
				c.sop  = SOP_IACC;
			end
			step_t'(8): begin
				c.sop = SOP_DACC;
			end
			step_t'(9): begin
				c.sop  = SOP_OUT;
				c.last = 1'b1;
			end
			default: begin
				c.last = 1'b1;
			end
		endcase
		return c;
	endfunction

	// divide by 2^16, rounding toward zero
	function automatic logic signed [63:0] trunc_shr16(input logic signed [63:0] x);
		logic signed [63:0] b;
		b = x + (x[63] ? 64'sd65535 : 64'sd0);
		return b >>> 16;
	endfunction

	// divide by 2^32, rounding toward zero
	function automatic logic signed [63:0] trunc_shr32(input logic signed [63:0] x);
		logic signed [63:0] b;
		b = x + (x[63] ? 64'sd4294967295 : 64'sd0);
		return b >>> 32;
	endfunction

	function automatic logic signed [49:0] clamp48(input logic signed [63:0] x);
		logic signed [49:0] r;
		if (x > TERM_LIM) begin
			r = TERM_LIM[49:0];
		end else if (x < TERM_LIM_NEG) begin
			r = TERM_LIM_NEG[49:0];
		end else begin
			r = x[49:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = 32'h7fff_ffff;
		end else if (x < -64'sd2147483648) begin
			r = 32'h8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== design/pid_filtered_derivative.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pid_filtered_derivative - PID controller with low-pass filtered derivative
// One signed Q16.16 error sample in, one saturated int16 drive value out, with
// the integrator, previous error and filtered derivative kept between ticks.
// ----------------------------------------------------------------------------
// Each transaction on the input occupies the sequencer from acceptance until
// it is free again: the acceptance and then ten microcode steps, one step per
// cycle unless the final step waits, set by the single shared 33x33 multiplier
// issuing at most one product per step. With both integral and derivative
// gains zero the program jumps from step 0 to step 5, past the rate, tick
// period and alpha multiplies. A new sample is taken whenever the sequencer is
// idle; the result sits in an output register until taken, and the final step
// waits only if that register is still full. Configuration writes are always
// accepted and must be made while no sample is in flight.
module pid_filtered_derivative (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	// error samples
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] error_sample
	// drive values
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [15:0] drive
	output logic             m_axis_tuser    // [0] drive_saturated
);

	// configuration
	logic signed [31:0] gain_p_q, gain_i_q, gain_d_q;
	logic [30:0]        int_limit_q;
	logic [15:0]        tick_period_q;
	logic [30:0]        tick_rate_q;
	logic [16:0]        deriv_alpha_q;

	// sequencer
	logic                busy_q;
	pfd_pkg::step_t      step_q;
	pfd_pkg::ctrl_t      ctrl;
	logic                in_acc, hold, run, jump_take, gi_nz, gd_nz;

	// loop state
	logic signed [31:0] integ_q, perr_q, pd_q;

	// datapath
	logic signed [31:0] err_q;
	logic signed [32:0] diff_q;
	logic signed [63:0] prod_q;
	logic signed [47:0] t_q;
	logic signed [47:0] hi_q;
	logic signed [63:0] w_q;
	logic signed [47:0] inc_q;
	logic signed [31:0] raw_q;
	logic signed [32:0] d2_q;
	logic signed [34:0] stp_q;
	logic signed [50:0] sum_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] mul_full;
	logic signed [63:0] prod_tr, w_tr, whole;
	logic signed [48:0] isum, ilim, ilim_n;
	logic signed [31:0] integ_nx, filt_nx, lim32, lim32_n;
	logic signed [35:0] filt_sum;
	logic signed [49:0] term_cl;

	// output register
	logic               out_valid_q;
	logic [15:0]        drive_q;
	logic               sat_q;
	logic [15:0]        drive_nx;
	logic               sat_nx;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !busy_q;
	assign in_acc        = s_axis_tvalid && !busy_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = drive_q;
	assign m_axis_tuser  = sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q      <= '0;
			gain_i_q      <= '0;
			gain_d_q      <= '0;
			int_limit_q   <= '0;
			tick_period_q <= pfd_pkg::TICK_PERIOD_RST;
			tick_rate_q   <= pfd_pkg::TICK_RATE_RST;
			deriv_alpha_q <= pfd_pkg::DERIV_ALPHA_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pfd_pkg::REG_GAIN_P:      gain_p_q      <= cfg_data;
				pfd_pkg::REG_GAIN_I:      gain_i_q      <= cfg_data;
				pfd_pkg::REG_GAIN_D:      gain_d_q      <= cfg_data;
				pfd_pkg::REG_INT_LIMIT:   int_limit_q   <= cfg_data[30:0];
				pfd_pkg::REG_TICK_PERIOD: tick_period_q <= cfg_data[15:0];
				pfd_pkg::REG_TICK_RATE:   tick_rate_q   <= cfg_data[30:0];
				pfd_pkg::REG_DERIV_ALPHA: deriv_alpha_q <= cfg_data[16:0];
				default: ;
			endcase
		end
	end

	assign gi_nz = |gain_i_q;
	assign gd_nz = |gain_d_q;

	// ---------------- sequencer ----------------
	assign ctrl      = pfd_pkg::ucode(step_q);
	assign hold      = busy_q && ctrl.last && out_valid_q && !m_axis_tready;
	assign run       = busy_q && !hold;
	assign jump_take = (ctrl.jmp == pfd_pkg::JMP_NO_ID) && !gi_nz && !gd_nz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (in_acc) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (run) begin
			if (ctrl.last) begin
				busy_q <= 1'b0;
			end else if (jump_take) begin
				step_q <= ctrl.target;
			end else begin
				step_q <= step_q + pfd_pkg::step_t'(1);
			end
		end
	end

	// ---------------- shared multiplier ----------------
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (ctrl.msel)
			pfd_pkg::MUL_GI: begin
				mul_a = {err_q[31], err_q};
				mul_b = {gain_i_q[31], gain_i_q};
			end
			pfd_pkg::MUL_RATE: begin
				mul_a = diff_q;
				mul_b = {2'b00, tick_rate_q};
			end
			pfd_pkg::MUL_TH: begin
				mul_a = {t_q[47], t_q[47:16]};
				mul_b = {17'd0, tick_period_q};
			end
			pfd_pkg::MUL_TL: begin
				mul_a = {17'd0, t_q[15:0]};
				mul_b = {17'd0, tick_period_q};
			end
			pfd_pkg::MUL_ALPHA: begin
				mul_a = d2_q;
				mul_b = {16'd0, deriv_alpha_q};
			end
			pfd_pkg::MUL_P: begin
				mul_a = {err_q[31], err_q};
				mul_b = {gain_p_q[31], gain_p_q};
			end
			pfd_pkg::MUL_GD: begin
				mul_a = {pd_q[31], pd_q};
				mul_b = {gain_d_q[31], gain_d_q};
			end
			default: ;
		endcase
	end

	assign mul_full = mul_a * mul_b;

	// ---------------- lane arithmetic ----------------
	assign prod_tr = pfd_pkg::trunc_shr16(prod_q);
	assign w_tr    = pfd_pkg::trunc_shr16(w_q);

	// integrator update, clamped to the limit
	assign isum   = {{17{integ_q[31]}}, integ_q} + {inc_q[47], inc_q};
	assign ilim   = {18'd0, int_limit_q};
	assign ilim_n = -ilim;

	always_comb begin
		if (isum > ilim) begin
			integ_nx = ilim[31:0];
		end else if (isum < ilim_n) begin
			integ_nx = ilim_n[31:0];
		end else begin
			integ_nx = isum[31:0];
		end
	end

	assign filt_sum = {{4{pd_q[31]}}, pd_q} + {stp_q[34], stp_q};
	assign filt_nx  = pfd_pkg::sat32({{28{filt_sum[35]}}, filt_sum});
	assign term_cl  = pfd_pkg::clamp48(prod_q);

	// truncate the Q32.32 sum to an integer and saturate to int16
	assign whole = pfd_pkg::trunc_shr32({{13{sum_q[50]}}, sum_q});

	always_comb begin
		if (whole > 64'sd32767) begin
			drive_nx = 16'h7fff;
			sat_nx   = 1'b1;
		end else if (whole < -64'sd32768) begin
			drive_nx = 16'h8000;
			sat_nx   = 1'b1;
		end else begin
			drive_nx = whole[15:0];
			sat_nx   = 1'b0;
		end
	end

	// ---------------- datapath registers ----------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			err_q  <= s_axis_tdata;
			diff_q <= {s_axis_tdata[31], s_axis_tdata} - {perr_q[31], perr_q};
		end
		if (run) begin
			if (ctrl.msel != pfd_pkg::MUL_NONE) begin
				prod_q <= mul_full[63:0];
			end
			unique case (ctrl.iop)
				pfd_pkg::IOP_T:   t_q   <= prod_tr[47:0];
				pfd_pkg::IOP_HI:  hi_q  <= prod_q[47:0];
				pfd_pkg::IOP_LO:  w_q   <= {hi_q, 16'd0} + prod_q;
				pfd_pkg::IOP_INC: inc_q <= w_tr[47:0];
				default: ;
			endcase
			unique case (ctrl.dop)
				pfd_pkg::DOP_RAW:  raw_q <= pfd_pkg::sat32(prod_tr);
				pfd_pkg::DOP_DIF2: d2_q  <= {raw_q[31], raw_q} - {pd_q[31], pd_q};
				pfd_pkg::DOP_STEP: stp_q <= prod_tr[34:0];
				default: ;
			endcase
			unique case (ctrl.sop)
				pfd_pkg::SOP_PSUM: sum_q <= {term_cl[49], term_cl};
				pfd_pkg::SOP_IACC: begin
					if (gi_nz) begin
						sum_q <= sum_q + {{3{integ_q[31]}}, integ_q, 16'd0};
					end
				end
				pfd_pkg::SOP_DACC: begin
					if (gd_nz) begin
						sum_q <= sum_q + {term_cl[49], term_cl};
					end
				end
				pfd_pkg::SOP_OUT: begin
					drive_q <= drive_nx;
					sat_q   <= sat_nx;
				end
				default: ;
			endcase
		end
	end

	// loop state, committed only when its gain is non-zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q <= '0;
			perr_q  <= '0;
			pd_q    <= '0;
		end else if (run) begin
			if (ctrl.iop == pfd_pkg::IOP_INTEG && gi_nz) begin
				integ_q <= integ_nx;
			end
			if (ctrl.dop == pfd_pkg::DOP_FILT && gd_nz) begin
				pd_q   <= filt_nx;
				perr_q <= err_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run && ctrl.sop == pfd_pkg::SOP_OUT) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// ---------------- assertions ----------------
	assign lim32   = {1'b0, int_limit_q};
	assign lim32_n = -lim32;

	a_integ_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(run && ctrl.iop == pfd_pkg::IOP_INTEG && gi_nz)
		|=> (integ_q <= lim32 && integ_q >= lim32_n))
		else $error("integrator outside clamp after update");

	a_sat_value: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser)
		|-> (m_axis_tdata == 16'h7fff || m_axis_tdata == 16'h8000))
		else $error("saturation flag without a rail value");

	a_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(ctrl.last))
		else $error("sequencer left busy before the final step");

	a_hold_step: assert property (@(posedge clk) disable iff (!arst_n)
		hold |=> (busy_q && $stable(step_q)))
		else $error("final step lost while output register full");

endmodule
`default_nettype wire
